>>> rtl/core/pdrc_pkg.sv
// ----------------------------------------------------------------------------
// pdrc_pkg: shared definitions for the PWM duty ramp controller
// Field widths, request and register codes, stage structs and the level table.
// ----------------------------------------------------------------------------
package pdrc_pkg;

    localparam int PWM_BITS   = 10;
    localparam int PCT_W      = 7;
    localparam int REQ_W      = 8;
    localparam int KIND_W     = 3;
    localparam int RAMP_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int PROD_W     = 2 * PCT_W;
    localparam int DIV_W      = 27;
    localparam int LUT_DEPTH  = 1 << PCT_W;
    localparam int PWM_MAX    = (1 << PWM_BITS) - 1;
    localparam int PCT_SCALE  = 100;

    // x / 100 == (x * 5243) >> 19 for every x below 43690, well above 100 * 127.
    localparam int DIV100_MULT  = 5243;
    localparam int DIV100_SHIFT = 19;

    typedef logic [PCT_W-1:0]    pct_t;
    typedef logic [PCT_W:0]      pct_sum_t;
    typedef logic [REQ_W-1:0]    req_pct_t;
    typedef logic [RAMP_W-1:0]   ramp_t;
    typedef logic [PROD_W-1:0]   prod_t;
    typedef logic [DIV_W-1:0]    div_t;
    typedef logic [PWM_BITS-1:0] level_t;

    localparam pct_t     PCT_FULL      = pct_t'(PCT_SCALE);
    localparam req_pct_t REQ_FULL      = req_pct_t'(PCT_SCALE);
    localparam ramp_t    MS_SATURATED  = '1;
    localparam pct_t     RST_STOP      = pct_t'(10);
    localparam pct_t     RST_FLOOR     = pct_t'(20);
    localparam pct_t     RST_CEILING   = pct_t'(100);
    localparam ramp_t    RST_RAMP      = ramp_t'(10);

    typedef enum logic [KIND_W-1:0] {
        REQ_TICK       = 3'd0,
        REQ_CONTROL    = 3'd1,
        REQ_SET_DUTY   = 3'd2,
        REQ_SET_ENABLE = 3'd3,
        REQ_SET_DIR    = 3'd4
    } req_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STOP_THRESHOLD = 2'd0,
        CFG_DUTY_FLOOR     = 2'd1,
        CFG_DUTY_CEILING   = 2'd2,
        CFG_RAMP_INTERVAL  = 2'd3
    } cfg_index_t;

    // Command handed to the ramp state once its target duty is mapped.
    typedef struct packed {
        req_kind_t kind;
        logic      enable;
        logic      forward;
        pct_t      target;
    } pdrc_cmd_t;

    typedef struct packed {
        level_t pwm_level;
        logic   phase_out;
        pct_t   duty_now;
        pct_t   duty_goal;
        logic   changed_flag;
    } pdrc_result_t;

    typedef level_t level_lut_t [0:LUT_DEPTH-1];

    function automatic level_lut_t build_level_lut();
        level_lut_t lut;
        for (int i = 0; i < LUT_DEPTH; i++)
        begin
            lut[i] = level_t'((PWM_MAX * i) / PCT_SCALE);
        end
        return lut;
    endfunction

    // PWM compare value for each duty percent.
    localparam level_lut_t LEVEL_LUT = build_level_lut();

endpackage

>>> rtl/core/pdrc_in_if.sv
// ----------------------------------------------------------------------------
// pdrc_in_if: request channel of the PWM duty ramp controller
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface pdrc_in_if;
    logic                            valid;
    logic                            ready;
    logic [pdrc_pkg::KIND_W-1:0]     req_type;
    logic                            enable_flag;
    logic                            forward_flag;
    logic [pdrc_pkg::REQ_W-1:0]      duty_request;

    modport source (
        output valid, req_type, enable_flag, forward_flag, duty_request,
        input  ready
    );

    modport sink (
        input  valid, req_type, enable_flag, forward_flag, duty_request,
        output ready
    );
endinterface

>>> rtl/core/pdrc_out_if.sv
// ----------------------------------------------------------------------------
// pdrc_out_if: result channel of the PWM duty ramp controller
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface pdrc_out_if;
    logic                            valid;
    logic                            ready;
    logic [pdrc_pkg::PWM_BITS-1:0]   pwm_level;
    logic                            phase_out;
    logic [pdrc_pkg::PCT_W-1:0]      duty_now;
    logic [pdrc_pkg::PCT_W-1:0]      duty_goal;
    logic                            changed_flag;

    modport source (
        output valid, pwm_level, phase_out, duty_now, duty_goal, changed_flag,
        input  ready
    );

    modport sink (
        input  valid, pwm_level, phase_out, duty_now, duty_goal, changed_flag,
        output ready
    );
endinterface

>>> rtl/core/pdrc_ramp_state.sv
// ----------------------------------------------------------------------------
// pdrc_ramp_state: duty, enable, direction and ramp timer state
// Applies one mapped command per cycle while fire is high and forms the matching result word.
// ----------------------------------------------------------------------------
module pdrc_ramp_state (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  pdrc_pkg::pdrc_cmd_t    cmd,
    input  pdrc_pkg::ramp_t        ramp_interval,
    output pdrc_pkg::pdrc_result_t result
);

    pdrc_pkg::pct_t  duty_cur_reg;
    pdrc_pkg::pct_t  duty_cur_next;
    pdrc_pkg::pct_t  duty_tgt_reg;
    pdrc_pkg::pct_t  duty_tgt_next;
    logic            enabled_reg;
    logic            enabled_next;
    logic            forward_reg;
    logic            forward_next;
    pdrc_pkg::ramp_t ms_reg;
    pdrc_pkg::ramp_t ms_next;
    pdrc_pkg::ramp_t ms_inc;
    logic            changed;

    always_comb
    begin
        duty_cur_next = duty_cur_reg;
        duty_tgt_next = duty_tgt_reg;
        enabled_next  = enabled_reg;
        forward_next  = forward_reg;
        ms_next       = ms_reg;
        ms_inc        = (ms_reg == pdrc_pkg::MS_SATURATED) ? ms_reg
                                                           : ms_reg + pdrc_pkg::ramp_t'(1);
        changed       = 1'b0;

        case (cmd.kind)
            pdrc_pkg::REQ_TICK:
            begin
                ms_next = ms_inc;
                if (duty_cur_reg != duty_tgt_reg && ms_inc >= ramp_interval)
                begin
                    ms_next = '0;
                    if (duty_cur_reg < duty_tgt_reg)
                        duty_cur_next = duty_cur_reg + pdrc_pkg::pct_t'(1);
                    else
                        duty_cur_next = duty_cur_reg - pdrc_pkg::pct_t'(1);
                end
            end
            pdrc_pkg::REQ_CONTROL:
            begin
                forward_next = cmd.forward;
                if (cmd.enable)
                begin
                    enabled_next  = 1'b1;
                    duty_tgt_next = cmd.target;
                end
                else
                begin
                    enabled_next  = 1'b0;
                    duty_tgt_next = '0;
                    duty_cur_next = '0;
                end
                changed = (duty_tgt_next != duty_tgt_reg) || (forward_next != forward_reg)
                          || (enabled_next != enabled_reg);
            end
            pdrc_pkg::REQ_SET_DUTY:
            begin
                duty_tgt_next = cmd.target;
            end
            pdrc_pkg::REQ_SET_ENABLE:
            begin
                if (cmd.enable)
                    enabled_next = 1'b1;
                else
                begin
                    enabled_next  = 1'b0;
                    duty_tgt_next = '0;
                    duty_cur_next = '0;
                end
            end
            pdrc_pkg::REQ_SET_DIR:
            begin
                forward_next = cmd.forward;
            end
            default:
            begin
            end
        endcase

        result.pwm_level    = (!enabled_next || duty_cur_next == '0)
                              ? '0 : pdrc_pkg::LEVEL_LUT[duty_cur_next];
        result.phase_out    = forward_next;
        result.duty_now     = duty_cur_next;
        result.duty_goal    = duty_tgt_next;
        result.changed_flag = changed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_cur_reg <= '0;
            duty_tgt_reg <= '0;
            enabled_reg  <= 1'b1;
            forward_reg  <= 1'b1;
            ms_reg       <= pdrc_pkg::MS_SATURATED;
        end
        else if (fire)
        begin
            duty_cur_reg <= duty_cur_next;
            duty_tgt_reg <= duty_tgt_next;
            enabled_reg  <= enabled_next;
            forward_reg  <= forward_next;
            ms_reg       <= ms_next;
        end
    end

endmodule

>>> rtl/core/pwm_duty_ramp_controller_core.sv
// ----------------------------------------------------------------------------
// pwm_duty_ramp_controller_core: slew-limited PWM duty controller
// Maps duty requests into a configured window and ramps the applied duty.
// ----------------------------------------------------------------------------
//  Port       Direction  Handshake      Word
//  req        in         valid/ready    req_type, enable_flag, forward_flag,
//                                       duty_request
//  rsp        out        valid/ready    pwm_level, phase_out, duty_now,
//                                       duty_goal, changed_flag
//  wr_*       in         write enable   wr_index, wr_data (no read-back)
//
// One word is accepted per cycle while req.ready is high; a result passes
// through the multiply stage, the scale-by-reciprocal stage and the
// result register where the duty state is updated.
// Each of the three stages holds one word, so up to three words queue up
// while rsp is stalled, and req drops ready only once all stages are full.
// Reset clears all stages and loads the default register and state values.
// ----------------------------------------------------------------------------
module pwm_duty_ramp_controller_core (
    input  logic                                clk,
    input  logic                                rst_n,
    pdrc_in_if.sink                             req,
    pdrc_out_if.source                          rsp,
    input  logic                                wr_en,
    input  logic [pdrc_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [pdrc_pkg::CFG_DATA_W-1:0]     wr_data
);

    // Configuration registers
    pdrc_pkg::pct_t  stop_threshold_reg;
    pdrc_pkg::pct_t  duty_floor_reg;
    pdrc_pkg::pct_t  duty_ceiling_reg;
    pdrc_pkg::ramp_t ramp_interval_reg;

    // Stage 1: saturated request times window span
    logic                 s1_valid_reg;
    pdrc_pkg::req_kind_t  s1_kind_reg;
    logic                 s1_enable_reg;
    logic                 s1_forward_reg;
    logic                 s1_stop_reg;
    pdrc_pkg::prod_t      s1_prod_reg;

    // Stage 2: mapped command
    logic                 s2_valid_reg;
    pdrc_pkg::pdrc_cmd_t  s2_cmd_reg;
    pdrc_pkg::pdrc_cmd_t  s2_cmd_next;

    // Stage 3: result word
    logic                   s3_valid_reg;
    pdrc_pkg::pdrc_result_t s3_result_reg;
    pdrc_pkg::pdrc_result_t s3_result_next;

    logic                 s1_ready;
    logic                 s2_ready;
    logic                 s3_ready;
    logic                 fire;

    pdrc_pkg::pct_t       pct;
    pdrc_pkg::pct_t       span;
    pdrc_pkg::div_t       scaled;
    pdrc_pkg::pct_sum_t   quot;
    pdrc_pkg::pct_sum_t   mapped;
    pdrc_pkg::pct_t       clamped;

    assign s3_ready  = !s3_valid_reg || rsp.ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req.ready = s1_ready;
    assign fire      = s2_valid_reg && s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_threshold_reg <= pdrc_pkg::RST_STOP;
            duty_floor_reg     <= pdrc_pkg::RST_FLOOR;
            duty_ceiling_reg   <= pdrc_pkg::RST_CEILING;
            ramp_interval_reg  <= pdrc_pkg::RST_RAMP;
        end
        else if (wr_en)
        begin
            case (pdrc_pkg::cfg_index_t'(wr_index))
                pdrc_pkg::CFG_STOP_THRESHOLD: stop_threshold_reg <= wr_data[pdrc_pkg::PCT_W-1:0];
                pdrc_pkg::CFG_DUTY_FLOOR:     duty_floor_reg     <= wr_data[pdrc_pkg::PCT_W-1:0];
                pdrc_pkg::CFG_DUTY_CEILING:   duty_ceiling_reg   <= wr_data[pdrc_pkg::PCT_W-1:0];
                pdrc_pkg::CFG_RAMP_INTERVAL:  ramp_interval_reg  <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    // Stage 1 logic: saturate the request and multiply it by the window span.
    always_comb
    begin
        pct  = (req.duty_request > pdrc_pkg::REQ_FULL) ? pdrc_pkg::PCT_FULL
                                                       : req.duty_request[pdrc_pkg::PCT_W-1:0];
        span = (duty_ceiling_reg >= duty_floor_reg) ? duty_ceiling_reg - duty_floor_reg : '0;
    end

    // Stage 2 logic: divide by 100 through the reciprocal, add the floor, then clamp.
    always_comb
    begin
        scaled  = pdrc_pkg::div_t'(s1_prod_reg) * pdrc_pkg::div_t'(pdrc_pkg::DIV100_MULT);
        quot    = pdrc_pkg::pct_sum_t'(scaled >> pdrc_pkg::DIV100_SHIFT);
        mapped  = pdrc_pkg::pct_sum_t'(duty_floor_reg) + quot;
        clamped = (mapped > pdrc_pkg::pct_sum_t'(duty_ceiling_reg))
                  ? duty_ceiling_reg : mapped[pdrc_pkg::PCT_W-1:0];
        if (clamped > pdrc_pkg::PCT_FULL)
            clamped = pdrc_pkg::PCT_FULL;

        s2_cmd_next.kind    = s1_kind_reg;
        s2_cmd_next.enable  = s1_enable_reg;
        s2_cmd_next.forward = s1_forward_reg;
        s2_cmd_next.target  = s1_stop_reg ? '0 : clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= req.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && req.valid)
        begin
            s1_kind_reg    <= pdrc_pkg::req_kind_t'(req.req_type);
            s1_enable_reg  <= req.enable_flag;
            s1_forward_reg <= req.forward_flag;
            s1_stop_reg    <= pct < stop_threshold_reg;
            s1_prod_reg    <= pdrc_pkg::prod_t'(pct) * pdrc_pkg::prod_t'(span);
        end
        if (s2_ready && s1_valid_reg)
            s2_cmd_reg <= s2_cmd_next;
        if (fire)
            s3_result_reg <= s3_result_next;
    end

    pdrc_ramp_state u_ramp_state (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .cmd           (s2_cmd_reg),
        .ramp_interval (ramp_interval_reg),
        .result        (s3_result_next)
    );

    assign rsp.valid        = s3_valid_reg;
    assign rsp.pwm_level    = s3_result_reg.pwm_level;
    assign rsp.phase_out    = s3_result_reg.phase_out;
    assign rsp.duty_now     = s3_result_reg.duty_now;
    assign rsp.duty_goal    = s3_result_reg.duty_goal;
    assign rsp.changed_flag = s3_result_reg.changed_flag;

endmodule

>>> rtl/core/pdrc_checker.sv
// ----------------------------------------------------------------------------
// pdrc_checker: port-level checks for the PWM duty ramp controller
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module pdrc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [pdrc_pkg::PWM_BITS-1:0] pwm_level,
    input logic [pdrc_pkg::PCT_W-1:0]    duty_now,
    input logic [pdrc_pkg::PCT_W-1:0]    duty_goal,
    input logic                          phase_out,
    input logic                          changed_flag
);

    // A stalled result word must stay in place.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(pwm_level) && $stable(duty_now)
            && $stable(duty_goal) && $stable(phase_out) && $stable(changed_flag))
        else $error("result word changed while stalled");

    // Mapped targets are clamped to 100 and the current duty only ramps toward them.
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> duty_now <= pdrc_pkg::PCT_FULL && duty_goal <= pdrc_pkg::PCT_FULL)
        else $error("duty percent above 100");

    // The level is either forced off or the scaled current duty.
    a_level_scale: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pwm_level == '0 || pwm_level == pdrc_pkg::LEVEL_LUT[duty_now])
        else $error("pwm level does not match current duty");

    // No result can be pending in the first cycle after reset.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !rsp_valid)
        else $error("result valid straight out of reset");

endmodule

bind pwm_duty_ramp_controller_core pdrc_checker u_pdrc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .pwm_level    (rsp.pwm_level),
    .duty_now     (rsp.duty_now),
    .duty_goal    (rsp.duty_goal),
    .phase_out    (rsp.phase_out),
    .changed_flag (rsp.changed_flag)
);
